>>> src/sccb_pkg.sv
// ---------------------------------------------------------------------------
// sccb_pkg: shared types and constants for the SCCB register master
// Command codes, config register indexes and the front-to-back tick word.
// ---------------------------------------------------------------------------
package sccb_pkg;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] REG_DEV_ADDR   = 2'd0;
	localparam logic [1:0] REG_HALF_BIT   = 2'd1;
	localparam logic [1:0] REG_WR_ATTEMPT = 2'd2;
	localparam logic [1:0] REG_RD_ATTEMPT = 2'd3;

	// one classified tick, as handed from front to back
	typedef struct packed {
		logic       start;     // valid write/read command
		logic       is_read;
		logic [7:0] reg_addr;
		logic [7:0] data;      // write data or read count
		logic       sda;
	} tick_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drive;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       rx_last;
		logic       done;
		logic       ok;
		logic       busy;
	} result_t;

endpackage

>>> src/sccb_front.sv
// ---------------------------------------------------------------------------
// sccb_front: input decode
// Classifies each incoming tick and packs it into a tick word.
// ---------------------------------------------------------------------------
module sccb_front (
	input  logic [1:0]     command,
	input  logic [7:0]     reg_addr,
	input  logic [7:0]     write_data,
	input  logic [7:0]     read_count,
	input  logic           sda_sample,
	output sccb_pkg::tick_t tick
);
	always_comb begin
		tick.start    = (command == sccb_pkg::CMD_WRITE) || (command == sccb_pkg::CMD_READ);
		tick.is_read  = (command == sccb_pkg::CMD_READ);
		tick.reg_addr = reg_addr;
		tick.data     = tick.is_read ? read_count : write_data;
		tick.sda      = sda_sample;
	end
endmodule

>>> src/sccb_fifo.sv
// ---------------------------------------------------------------------------
// sccb_fifo: two-entry register queue
// Decouples the input handshake from the bit sequencer.
// ---------------------------------------------------------------------------
module sccb_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end
endmodule

>>> src/sccb_back.sv
// ---------------------------------------------------------------------------
// sccb_back: bit sequencer
// Runs start, byte, ack, stop and receive phases, one tick per step.
// ---------------------------------------------------------------------------
module sccb_back #(
	parameter int DELAY_WIDTH = 16,
	parameter int COUNT_WIDTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sccb_pkg::tick_t   tick,
	input  logic [7:0]        dev_addr,
	input  logic [15:0]       half_bit,
	input  logic [7:0]        wr_attempts,
	input  logic [7:0]        rd_attempts,
	output sccb_pkg::result_t res
);
	typedef enum logic [4:0] {
		M_IDLE, M_S0, M_S1, M_S2, M_S3, M_B0, M_B1, M_B2, M_A0, M_A1, M_A2,
		M_P0, M_P1, M_P2, M_R0, M_R1, M_R2, M_K1, M_K2, M_K3
	} phase_t;
	typedef enum logic [3:0] {
		G_START1, G_DEVW, G_REG, G_DATA, G_MIDSTOP, G_START2, G_DEVR, G_RX,
		G_ENDSTOP, G_FAILSTOP
	} stage_t;

	phase_t                 phase_q, ph;
	stage_t                 stage_q, st;
	logic [3:0]             bit_q, bi;
	logic [7:0]             sh_q, sh;
	logic [DELAY_WIDTH-1:0] dly_q, dl;
	logic [COUNT_WIDTH-1:0] att_q, at, lim;
	logic [COUNT_WIDTH-1:0] left_q, bl;
	logic [7:0]             ra_q, ra, hd_q, hd;
	logic                   rd_q, rd;
	logic                   scl_q, sda_q, drv_q, scl, sdl, drv;
	logic [7:0]             rx;
	logic                   rxv, rxl, dn, ok, go;
	logic [DELAY_WIDTH-1:0] h;

	always_comb begin
		ph = phase_q; st = stage_q; bi = bit_q; sh = sh_q; dl = dly_q; at = att_q;
		bl = left_q; ra = ra_q; hd = hd_q; rd = rd_q;
		scl = scl_q; sdl = sda_q; drv = drv_q;
		rx = '0; rxv = 1'b0; rxl = 1'b0; dn = 1'b0; ok = 1'b0; go = 1'b0;
		h = DELAY_WIDTH'(half_bit);
		lim = '0;
		if (phase_q == M_IDLE) begin
			if (tick.start) begin
				rd = tick.is_read; ra = tick.reg_addr; hd = tick.data;
				at = '0; st = G_START1; ph = M_S0; go = 1'b1;
			end
		end else if (dly_q != '0) begin
			dl = dly_q - 1'b1;
		end else begin
			go = 1'b1;
		end
		if (go) begin
			lim = rd ? COUNT_WIDTH'(rd_attempts) : COUNT_WIDTH'(wr_attempts);
			unique case (ph)
				M_S0: begin scl = 1'b1; sdl = 1'b1; drv = 1'b1; ph = M_S1; end
				M_S1: begin drv = 1'b0; ph = M_S2; end
				M_S2: begin
					drv = 1'b1;
					if (!tick.sda) ph = M_P2;          // fail path marker
					else begin sdl = 1'b0; ph = M_S3; end
				end
				M_S3: begin
					scl = 1'b0;
					if (tick.sda) ph = M_P2;
					else begin
						sh = (st == G_START1) ? dev_addr : dev_addr + 8'd1;
						st = (st == G_START1) ? G_DEVW : G_DEVR;
						bi = '0; ph = M_B0;
					end
				end
				M_B0: begin sdl = sh[7]; drv = 1'b1; sh = {sh[6:0], 1'b0}; ph = M_B1; end
				M_B1: begin scl = 1'b1; ph = M_B2; end
				M_B2: begin
					scl = 1'b0; bi = bi + 4'd1;
					if (bi >= 4'd8) begin bi = '0; ph = M_A0; end else ph = M_B0;
				end
				M_A0: begin scl = 1'b0; drv = 1'b0; ph = M_A1; end
				M_A1: begin scl = 1'b1; ph = M_A2; end
				M_A2: begin
					drv = 1'b1; scl = 1'b0;
					unique case (st)
						G_DEVW: begin
							if (tick.sda) begin st = G_FAILSTOP; ph = M_P0; end
							else begin sh = ra; bi = '0; st = G_REG; ph = M_B0; end
						end
						G_DEVR: begin
							if (tick.sda) begin st = G_FAILSTOP; ph = M_P0; end
							else begin
								bl = COUNT_WIDTH'(hd);
								if (bl == '0) begin st = G_ENDSTOP; ph = M_P0; end
								else begin st = G_RX; ph = M_R0; bi = '0; sh = '0; end
							end
						end
						G_REG: begin
							if (rd) begin st = G_MIDSTOP; ph = M_P0; end
							else begin sh = hd; bi = '0; st = G_DATA; ph = M_B0; end
						end
						default: begin st = G_ENDSTOP; ph = M_P0; end
					endcase
				end
				M_P0: begin scl = 1'b0; sdl = 1'b0; drv = 1'b1; ph = M_P1; end
				M_P1: begin scl = 1'b1; ph = M_P2; end
				M_R0: begin drv = 1'b0; scl = 1'b0; ph = M_R1; end
				M_R1: begin scl = 1'b1; ph = M_R2; end
				M_R2: begin
					sh = {sh[6:0], tick.sda}; scl = 1'b0; bi = bi + 4'd1;
					if (bi >= 4'd8) begin
						bi = '0; drv = 1'b1; rx = sh; rxv = 1'b1;
						rxl = (bl == COUNT_WIDTH'(1)); ph = M_K1;
					end else ph = M_R1;
				end
				M_K1: begin sdl = (bl == COUNT_WIDTH'(1)); drv = 1'b1; ph = M_K2; end
				M_K2: begin scl = 1'b1; ph = M_K3; end
				M_K3: begin
					scl = 1'b0; bl = bl - 1'b1;
					if (bl == '0) begin st = G_ENDSTOP; ph = M_P0; end
					else begin ph = M_R0; sh = '0; end
				end
				default: ph = M_IDLE;
			endcase
			// stop completion and failed start share the wrap-up logic
			if (phase_q == M_P2 || (go && (ph == M_P2) && (phase_q == M_S2 ||
			    phase_q == M_S3 || (phase_q == M_IDLE)) && !(phase_q == M_P1))) begin
				if (phase_q == M_P2) sdl = 1'b1;
				if (phase_q == M_P2 && st == G_MIDSTOP) begin st = G_START2; ph = M_S0; end
				else if (phase_q == M_P2 && st != G_FAILSTOP) begin
					ph = M_IDLE; dn = 1'b1; ok = 1'b1;
				end else begin
					at = at + 1'b1;
					if (at == lim) begin ph = M_IDLE; dn = 1'b1; end
					else begin st = G_START1; ph = M_S0; end
				end
			end
			if (ph != M_IDLE) dl = (h == '0) ? '0 : h - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= M_IDLE; stage_q <= G_START1; bit_q <= '0; sh_q <= '0;
			dly_q <= '0; att_q <= '0; left_q <= '0; ra_q <= '0; hd_q <= '0;
			rd_q <= 1'b0; scl_q <= 1'b1; sda_q <= 1'b1; drv_q <= 1'b1;
			res <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1, default: '0};
		end else if (step) begin
			phase_q <= ph; stage_q <= st; bit_q <= bi; sh_q <= sh; dly_q <= dl;
			att_q <= at; left_q <= bl; ra_q <= ra; hd_q <= hd; rd_q <= rd;
			scl_q <= scl; sda_q <= sdl; drv_q <= drv;
			res <= '{scl: scl, sda: sdl, drive: drv, rx_byte: rx, rx_valid: rxv,
			         rx_last: rxl, done: dn, ok: ok, busy: (ph != M_IDLE)};
		end
	end
endmodule

>>> src/sccb_register_master_core.sv
// ---------------------------------------------------------------------------
// sccb_register_master_core: SCCB camera register bus master
// Tick-driven bit sequencer with decoupled input queue and output register.
// ---------------------------------------------------------------------------
// Usage:
//  Each request on the input channel is one bus tick: an optional command
//  (write one register, or read a run) and the sampled data line level.
//  Every accepted request yields exactly one result on the output channel:
//  pin levels, any received byte, done/success and busy flags.
//  A two-entry queue sits between the input decode and the sequencer;
//  the sequencer advances one tick per clock whenever a request is queued
//  and its output register is free or being drained.
//  Throughput: one request per clock while the output is not stalled. A
//  request is written into the queue and then passes the sequencer result
//  register before its result is valid.
//  When the receiver stalls, the result holds, the sequencer pauses and
//  the queue fills; the input then deasserts ready. Bus timing is in
//  ticks, so stalls do not distort it.
//  Config writes (index 0..3) are taken at any time; they must only be
//  issued while the block is idle. Reset: idle, pins driven high,
//  registers at their default values.
// ---------------------------------------------------------------------------
module sccb_register_master_core #(
	parameter int DELAY_WIDTH = 16,
	parameter int COUNT_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  reg_addr,
	input  logic [7:0]  write_data,
	input  logic [7:0]  read_count,
	input  logic        sda_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_drive,
	output logic [7:0]  rx_byte,
	output logic        rx_valid,
	output logic        rx_last,
	output logic        done_res,
	output logic        success,
	output logic        busy_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	sccb_pkg::tick_t   tick_in, tick_q;
	sccb_pkg::result_t res;
	logic              full, empty, step, ov_q;
	logic [7:0]        dev_q, wra_q, rda_q;
	logic [15:0]       half_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= 8'd66; half_q <= 16'd100; wra_q <= 8'd20; rda_q <= 8'd30;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sccb_pkg::REG_DEV_ADDR:   dev_q  <= cfg_data[7:0];
				sccb_pkg::REG_HALF_BIT:   half_q <= cfg_data;
				sccb_pkg::REG_WR_ATTEMPT: wra_q  <= cfg_data[7:0];
				sccb_pkg::REG_RD_ATTEMPT: rda_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	sccb_front u_front (
		.command, .reg_addr, .write_data, .read_count, .sda_sample, .tick(tick_in)
	);

	assign in_ready = !full;
	assign step     = !empty && (!ov_q || out_ready);

	sccb_fifo #(.WIDTH($bits(sccb_pkg::tick_t))) u_fifo (
		.clk, .arst_n, .push(in_valid), .wdata(tick_in), .full,
		.pop(step), .rdata(tick_q), .empty
	);

	sccb_back #(.DELAY_WIDTH(DELAY_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk, .arst_n, .step, .tick(tick_q), .dev_addr(dev_q), .half_bit(half_q),
		.wr_attempts(wra_q), .rd_attempts(rda_q), .res
	);

	// output valid register; payload lives in the sequencer result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (step) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	assign out_valid = ov_q;
	assign scl_level = res.scl;
	assign sda_level = res.sda;
	assign sda_drive = res.drive;
	assign rx_byte   = res.rx_byte;
	assign rx_valid  = res.rx_valid;
	assign rx_last   = res.rx_last;
	assign done_res  = res.done;
	assign success   = res.ok;
	assign busy_res  = res.busy;

	// success only reported with done
	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && success |-> done_res) else $error("success without done");
	// last flag only with a received byte
	a_last_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_last |-> rx_valid) else $error("rx_last without rx_valid");
	// a stalled result holds its clock level and data-line drive enable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(scl_level) && $stable(sda_drive))
		else $error("result changed under stall");
endmodule
